>>> hw/rtl/dosf_pkg.sv
// shared types, constants and codes of the drop-oldest sample fifo
package dosf_pkg;

  // ring size in samples, a power of two
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  // sample counts run from 0 to DEPTH
  localparam int unsigned CNT_W = 11;
  localparam int unsigned SMP_W = 16;
  localparam int unsigned BURST_W = 16;

  localparam logic [CNT_W-1:0] MAX_SAMPLES_RST = CNT_W'(1024);

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_TRUNC = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [SMP_W-1:0] sample_in;
    logic [BURST_W-1:0]      count;
    logic                    first_of_burst;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] read_sample;
    logic                    read_valid;
    logic                    write_accepted;
    logic [CNT_W-1:0]        dropped;
    logic [CNT_W-1:0]        occupancy;
    logic signed [SMP_W-1:0] newest_sample;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic capture;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mem_read;
  } sts_t;

endpackage

>>> hw/rtl/dosf_ram.sv
// generic single-write, single-read ram with registered read data
module dosf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/dosf_ctrl.sv
// controller state machine of the drop-oldest sample fifo
module dosf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  dosf_pkg::sts_t sts_i,
  output dosf_pkg::cmd_t cmd_o
);

  dosf_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dosf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.mem_read ? dosf_pkg::ST_MEM : dosf_pkg::ST_OUT;
        end
      end
      dosf_pkg::ST_MEM: begin
        state_d = dosf_pkg::ST_OUT;
      end
      dosf_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          state_d = dosf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dosf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      dosf_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.load   = in_valid_i;
      end
      dosf_pkg::ST_MEM: begin
        cmd_o.capture = 1'b1;
      end
      dosf_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dosf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // one transaction in flight: a result never waits beside a new intake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result pending while input open");

  // a memory read always lands as a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> out_valid_o)
    else $error("captured read did not reach the output");

endmodule

>>> hw/rtl/dosf_dp.sv
// datapath of the drop-oldest sample fifo: ring pointers, limit, sample ram, result
module dosf_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dosf_pkg::CNT_W-1:0]     cfg_wdata_i,
  input  dosf_pkg::in_item_t             in_item_i,
  input  dosf_pkg::cmd_t                 cmd_i,
  output dosf_pkg::sts_t                 sts_o,
  output dosf_pkg::out_item_t            out_item_o
);

  localparam int unsigned AW = dosf_pkg::ADDR_W;
  localparam int unsigned CW = dosf_pkg::CNT_W;
  localparam int unsigned BW = dosf_pkg::BURST_W;

  logic [CW-1:0] max_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] held_q, held_d;
  logic          rej_q, rej_d;
  logic signed [dosf_pkg::SMP_W-1:0] newest_q, newest_d;
  dosf_pkg::out_item_t res_q, res_d;

  logic [CW-1:0] lim;
  logic [BW:0]   fill_sum;
  logic          burst_over;
  logic          rej_now;
  logic [CW-1:0] drop_fit;
  logic [CW-1:0] held_fit;
  logic [AW-1:0] head_fit;
  logic [CW-1:0] drop_full;
  logic [CW-1:0] held_wr;
  logic [AW-1:0] head_wr;
  logic          do_store;
  logic          trunc_hit;
  logic [CW-1:0] trunc_drop;

  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  logic [dosf_pkg::SMP_W-1:0] ram_rdata;

  // limit in use, never above the ring size
  assign lim = (max_q > CW'(dosf_pkg::DEPTH)) ? CW'(dosf_pkg::DEPTH) : max_q;

  // burst start: reject, or make room for the whole burst
  assign fill_sum   = (BW+1)'(held_q) + (BW+1)'(in_item_i.count);
  assign burst_over = in_item_i.count > BW'(lim);
  assign rej_now    = in_item_i.first_of_burst ? burst_over : rej_q;
  assign drop_fit   = (in_item_i.first_of_burst && !burst_over && (fill_sum > (BW+1)'(lim)))
                      ? CW'(fill_sum - (BW+1)'(lim)) : '0;
  assign held_fit   = held_q - drop_fit;
  assign head_fit   = head_q + drop_fit[AW-1:0];

  // still at the limit: drop the oldest to fit this one sample
  assign drop_full  = (held_fit >= lim) ? (held_fit - lim + CW'(1)) : '0;
  assign held_wr    = held_fit - drop_full;
  assign head_wr    = head_fit + drop_full[AW-1:0];
  assign ram_waddr  = head_wr + held_wr[AW-1:0];
  assign do_store   = !rej_now && (lim != '0);

  assign trunc_hit  = BW'(held_q) > in_item_i.count;
  assign trunc_drop = held_q - CW'(in_item_i.count);

  assign sts_o.mem_read = (in_item_i.mode == dosf_pkg::MODE_READ) && (held_q != '0);

  always_comb begin
    head_d   = head_q;
    held_d   = held_q;
    rej_d    = rej_q;
    newest_d = newest_q;
    res_d    = '0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    unique case (in_item_i.mode)
      dosf_pkg::MODE_WRITE: begin
        rej_d = rej_now;
        if (do_store) begin
          ram_we               = cmd_i.load;
          head_d               = head_wr;
          held_d               = held_wr + CW'(1);
          newest_d             = in_item_i.sample_in;
          res_d.write_accepted = 1'b1;
          res_d.dropped        = drop_fit + drop_full;
        end else begin
          head_d        = head_fit;
          held_d        = held_fit;
          res_d.dropped = drop_fit;
        end
      end
      dosf_pkg::MODE_READ: begin
        if (held_q != '0) begin
          ram_re           = cmd_i.load;
          head_d           = head_q + AW'(1);
          held_d           = held_q - CW'(1);
          res_d.read_valid = 1'b1;
        end
      end
      dosf_pkg::MODE_TRUNC: begin
        if (trunc_hit) begin
          head_d        = head_q + trunc_drop[AW-1:0];
          held_d        = CW'(in_item_i.count);
          res_d.dropped = trunc_drop;
        end
      end
      dosf_pkg::MODE_NOP: begin
        held_d = held_q;
      end
      default: begin
        held_d = held_q;
      end
    endcase
    res_d.occupancy     = held_d;
    res_d.newest_sample = (held_d == '0) ? '0 : newest_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= dosf_pkg::MAX_SAMPLES_RST;
      head_q <= '0;
      held_q <= '0;
      rej_q  <= 1'b0;
    end else if (cfg_we_i) begin
      max_q  <= cfg_wdata_i;
      head_q <= '0;
      held_q <= '0;
      rej_q  <= 1'b0;
    end else if (cmd_i.load) begin
      head_q <= head_d;
      held_q <= held_d;
      rej_q  <= rej_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      newest_q <= newest_d;
      res_q    <= res_d;
    end else if (cmd_i.capture) begin
      res_q.read_sample <= ram_rdata;
    end
  end

  dosf_ram #(
    .Width (dosf_pkg::SMP_W),
    .Depth (dosf_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_item_i.sample_in),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign out_item_o = res_q;

  // the fill never exceeds the limit in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= lim)
    else $error("fill above limit");

  // a store and a pop never happen for the same transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("ram written and read for one transaction");

endmodule

>>> hw/rtl/drop_oldest_sample_fifo_unit.sv
// top level of the drop-oldest sample fifo: controller, datapath and sample ram
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/in_stall_o  in_item_i  (dosf_pkg::in_item_t)
//   out      output     out_valid_o/out_stall_i out_item_o (dosf_pkg::out_item_t)
//   cfg      input      cfg_we_i               cfg_wdata_i (max_samples)
//
// one transaction at a time: write, truncate and no-op items and reads of an empty
// ring go from intake straight to the result state, a read of a held sample waits in
// the ram state first (registered ram read port); the input stays stalled until the
// result transaction completes, so no new item is taken while one is in flight
// reset empties the ring, clears the rejected-burst flag and sets the limit to 1024
// a config write empties the ring the same way and needs no clearing pass
module drop_oldest_sample_fifo_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input item channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  dosf_pkg::in_item_t           in_item_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output dosf_pkg::out_item_t          out_item_o,
  // sample limit register
  input  logic                         cfg_we_i,
  input  logic [dosf_pkg::CNT_W-1:0]   cfg_wdata_i
);

  // command and status between the two halves
  dosf_pkg::cmd_t cmd;
  dosf_pkg::sts_t sts;

  // sequencing: intake, optional ram read wait, result hold
  dosf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // ring pointers, limit register, sample ram and the result register
  dosf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_item_o  (out_item_o)
  );

endmodule

>>> tb/drop_oldest_sample_fifo_unit_test.sv
// self-checking testbench for the drop-oldest sample fifo with its own ring predictor
`timescale 1ns / 100ps

module drop_oldest_sample_fifo_unit_test;
  import dosf_pkg::*;

  // run length guard, counted in clock cycles
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // quiet cycles after the last result before a register write or the end
  localparam int unsigned SETTLE_CYCLES = 8;
  // long receiver hold-off of the back-pressure test
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS_PER_PHASE = 32;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  drop_oldest_sample_fifo_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predicted ring contents, mirrored from the accepted transactions
  logic signed [SMP_W-1:0] ring_store [DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_held = 0;
  logic burst_blocked = 1'b0;
  logic [CNT_W-1:0] limit_reg = MAX_SAMPLES_RST;

  // results still owed by the block, oldest first
  out_item_t expected_results [$];
  int unsigned items_sent = 0;
  logic fail_seen = 1'b0;

  // idling on both channels; cleared for stretches with back-to-back traffic
  logic idling_on = 1'b1;

  // receiver stall state, owned by the result process; the back-pressure test toggles hold_flip
  logic hold_flip = 1'b0;
  logic hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  // mostly short idle runs, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic signed [SMP_W-1:0] rand_sample();
    return SMP_W'($urandom);
  endfunction

  function automatic in_item_t make_item(mode_e mode, logic signed [SMP_W-1:0] sample,
                                         logic [BURST_W-1:0] count, logic first);
    in_item_t item;
    item.mode = mode;
    item.sample_in = sample;
    item.count = count;
    item.first_of_burst = first;
    return item;
  endfunction

  function automatic void discard_oldest(int unsigned n);
    ring_head = (ring_head + n) % DEPTH;
    ring_held -= n;
  endfunction

  // next result of the ring for one accepted transaction; updates the mirror
  function automatic out_item_t predict_fifo(in_item_t item);
    out_item_t res;
    int unsigned lim;
    int unsigned lost;
    int unsigned extra;
    res = '0;
    lost = 0;
    // limits above the ring size act as the ring size
    lim = (limit_reg > DEPTH) ? DEPTH : limit_reg;
    case (item.mode)
      MODE_WRITE: begin
        if (item.first_of_burst) begin
          // a burst that can never fit is refused whole
          burst_blocked = (item.count > lim);
          if (!burst_blocked && ring_held + item.count > lim) begin
            lost = ring_held + item.count - lim;
            discard_oldest(lost);
          end
        end
        if (!burst_blocked && lim != 0) begin
          // writing into a full ring pushes out the oldest sample
          if (ring_held >= lim) begin
            extra = ring_held - lim + 1;
            discard_oldest(extra);
            lost += extra;
          end
          ring_store[(ring_head + ring_held) % DEPTH] = item.sample_in;
          ring_held++;
          res.write_accepted = 1'b1;
        end
      end
      MODE_READ: begin
        if (ring_held != 0) begin
          res.read_sample = ring_store[ring_head];
          res.read_valid = 1'b1;
          discard_oldest(1);
        end
      end
      MODE_TRUNC: begin
        if (ring_held > item.count) begin
          lost = ring_held - item.count;
          discard_oldest(lost);
        end
      end
      default: ;
    endcase
    res.dropped = CNT_W'(lost);
    res.occupancy = CNT_W'(ring_held);
    res.newest_sample = (ring_held != 0) ? ring_store[(ring_head + ring_held - 1) % DEPTH] : '0;
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_seen = 1'b1;
    end
  endfunction

  // offer one transaction, wait for it to be taken, then record its result
  // valid is left high on return so a back-to-back item follows without dropping valid
  task automatic send_fifo_item(input in_item_t item);
    int unsigned gap;
    gap = (idling_on && $urandom_range(0, 99) >= 60) ? idle_length() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(predict_fifo(item));
    items_sent++;
  endtask

  // drop valid and wait until every owed result has come back
  task automatic settle_fifo();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // the limit is only written with the block idle; a write empties the ring
  task automatic write_limit(input logic [CNT_W-1:0] value);
    settle_fifo();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_reg = value;
    ring_head = 0;
    ring_held = 0;
    burst_blocked = 1'b0;
  endtask

  // result side: compare each completed transaction, then pick the next stall
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_seen = 1'b1;
      end else begin
        want = expected_results.pop_front();
        check_field("read_sample", want.read_sample, out_item_o.read_sample);
        check_field("read_valid", want.read_valid, out_item_o.read_valid);
        check_field("write_accepted", want.write_accepted, out_item_o.write_accepted);
        check_field("dropped", want.dropped, out_item_o.dropped);
        check_field("occupancy", want.occupancy, out_item_o.occupancy);
        check_field("newest_sample", want.newest_sample, out_item_o.newest_sample);
      end
    end
    // a flip of hold_flip starts the long hold-off
    if (hold_seen != hold_flip) begin
      hold_seen = hold_flip;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idling_on && $urandom_range(0, 9) < 3) begin
      stall_left = idle_length() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // reset limit, empty reads, nop, burst edges and truncation
  task automatic test_basic_directed();
    send_fifo_item(make_item(MODE_READ, 16'sh1234, 16'd0, 1'b0));
    send_fifo_item(make_item(MODE_NOP, 16'sh7FFF, 16'hFFFF, 1'b1));
    send_fifo_item(make_item(MODE_TRUNC, '0, 16'd0, 1'b0));
    send_fifo_item(make_item(MODE_WRITE, 16'sh7FFF, 16'd3, 1'b1));
    send_fifo_item(make_item(MODE_WRITE, -16'sd32768, 16'd0, 1'b0));
    send_fifo_item(make_item(MODE_WRITE, 16'sd0, 16'd0, 1'b0));
    // one more than declared
    send_fifo_item(make_item(MODE_WRITE, 16'sh5555, 16'd0, 1'b0));
    // refused burst and a write inside it
    send_fifo_item(make_item(MODE_WRITE, -16'sd1, 16'hFFFF, 1'b1));
    send_fifo_item(make_item(MODE_WRITE, 16'sh2AAA, 16'd0, 1'b0));
    // zero-length burst still stores its sample
    send_fifo_item(make_item(MODE_WRITE, -16'sd2, 16'd0, 1'b1));
    send_fifo_item(make_item(MODE_TRUNC, '0, 16'hFFFF, 1'b0));
    send_fifo_item(make_item(MODE_TRUNC, '0, 16'd2, 1'b0));
    repeat (3) send_fifo_item(make_item(MODE_READ, '0, 16'd0, 1'b0));
  endtask

  // zero limit never stores; a tiny limit drops at burst start and when full
  task automatic test_zero_and_tiny_limits();
    write_limit(CNT_W'(0));
    send_fifo_item(make_item(MODE_WRITE, 16'sh0101, 16'd0, 1'b1));
    send_fifo_item(make_item(MODE_WRITE, 16'sh0202, 16'd1, 1'b1));
    send_fifo_item(make_item(MODE_READ, '0, 16'd0, 1'b0));
    write_limit(CNT_W'(2));
    send_fifo_item(make_item(MODE_WRITE, 16'sh0011, 16'd2, 1'b1));
    send_fifo_item(make_item(MODE_WRITE, 16'sh0022, 16'd0, 1'b0));
    send_fifo_item(make_item(MODE_WRITE, 16'sh0033, 16'd2, 1'b1));
    send_fifo_item(make_item(MODE_WRITE, 16'sh0044, 16'd0, 1'b0));
    send_fifo_item(make_item(MODE_WRITE, 16'sh0055, 16'd0, 1'b0));
  endtask

  // whole ring at the clamped maximum limit, back to back
  task automatic test_full_ring();
    write_limit(CNT_W'(2047));
    idling_on = 1'b0;
    send_fifo_item(make_item(MODE_WRITE, rand_sample(), BURST_W'(DEPTH), 1'b1));
    for (int k = 1; k < DEPTH; k++)
      send_fifo_item(make_item(MODE_WRITE, rand_sample(), 16'd0, 1'b0));
    idling_on = 1'b1;
    repeat (2) send_fifo_item(make_item(MODE_WRITE, rand_sample(), 16'd0, 1'b0));
    // just over the clamped limit is refused
    send_fifo_item(make_item(MODE_WRITE, rand_sample(), BURST_W'(DEPTH + 1), 1'b1));
    send_fifo_item(make_item(MODE_TRUNC, '0, BURST_W'(DEPTH - 1), 1'b0));
    send_fifo_item(make_item(MODE_READ, '0, 16'd0, 1'b0));
    send_fifo_item(make_item(MODE_TRUNC, '0, BURST_W'(DEPTH - 1), 1'b0));
    // a full-size burst flushes every held sample
    send_fifo_item(make_item(MODE_WRITE, 16'sh0F0F, BURST_W'(DEPTH), 1'b1));
    send_fifo_item(make_item(MODE_WRITE, rand_sample(), BURST_W'(DEPTH), 1'b1));
    send_fifo_item(make_item(MODE_TRUNC, '0, 16'd0, 1'b0));
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    write_limit(CNT_W'(8));
    idling_on = 1'b0;
    hold_flip <= ~hold_flip;
    send_fifo_item(make_item(MODE_WRITE, rand_sample(), 16'd8, 1'b1));
    repeat (9) send_fifo_item(make_item(MODE_WRITE, rand_sample(), 16'd0, 1'b0));
    repeat (10) send_fifo_item(make_item(MODE_READ, '0, 16'd0, 1'b0));
    idling_on = 1'b1;
  endtask

  // random traffic under several limits: mostly well-formed bursts
  task automatic test_random_traffic();
    int unsigned phase_limits [6] = '{3, 1, 16, 0, 2047, 8};
    int unsigned lim;
    int unsigned burst_len;
    int unsigned burst_items;
    int unsigned stop_at;
    int unsigned roll;
    foreach (phase_limits[p]) begin
      write_limit(CNT_W'(phase_limits[p]));
      lim = (phase_limits[p] > DEPTH) ? DEPTH : phase_limits[p];
      stop_at = items_sent + RANDOM_ITEMS_PER_PHASE;
      while (items_sent < stop_at) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          burst_len = $urandom_range(0, (lim < 40) ? lim : 40);
          burst_items = (burst_len == 0) ? 1 : burst_len;
          // now and then a burst runs past its declared length
          if ($urandom_range(0, 7) == 0) burst_items += $urandom_range(1, 3);
          // now and then a burst that cannot fit
          if ($urandom_range(0, 9) == 0) begin
            burst_len = lim + $urandom_range(1, 3);
            burst_items = $urandom_range(1, 6);
          end
          send_fifo_item(make_item(MODE_WRITE, rand_sample(), BURST_W'(burst_len), 1'b1));
          for (int k = 1; k < burst_items; k++)
            send_fifo_item(make_item(MODE_WRITE, rand_sample(), BURST_W'($urandom), 1'b0));
        end else if (roll < 72) begin
          repeat ($urandom_range(1, 4))
            send_fifo_item(make_item(MODE_READ, rand_sample(), BURST_W'($urandom), 1'b0));
        end else if (roll < 85) begin
          send_fifo_item(make_item(MODE_TRUNC, rand_sample(),
                                   BURST_W'($urandom_range(0, lim + 2)), 1'($urandom)));
        end else begin
          // anything the fields allow
          send_fifo_item(make_item(mode_e'($urandom_range(0, 3)), rand_sample(),
                                   BURST_W'($urandom), 1'($urandom)));
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_directed();
    test_zero_and_tiny_limits();
    test_full_ring();
    test_backpressure();
    test_random_traffic();
    settle_fifo();
    if (!fail_seen) begin
      $display("drop_oldest_sample_fifo_unit_test: PASS");
    end else begin
      $display("drop_oldest_sample_fifo_unit_test: FAIL");
    end
    $finish;
  end

  // watchdog on the whole run
  initial begin : watchdog
    int unsigned cycles_run;
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("drop_oldest_sample_fifo_unit_test: FAIL");
    $finish;
  end

endmodule
